// ===== hdl/flux_cell_stream_encoder_macros.svh =====
// Assertion macros for the flux cell stream encoder checker.
// Used by the checker module only; no other dependencies.
`ifndef FLUX_CELL_STREAM_ENCODER_MACROS_SVH
`define FLUX_CELL_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/fce_pkg.sv =====
// Shared types and constants for the flux cell stream encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fce_pkg;

    // record layout sizes in bytes
    localparam int HEADER_BYTES     = 4;
    localparam int INDEX_BODY_BYTES = 12;
    localparam int READ_BODY_BYTES  = 8;

    // file offset (mod 16) bookkeeping
    localparam logic [3:0] FOL_RESET      = 4'((HEADER_BYTES + READ_BODY_BYTES) % 16);
    localparam logic [3:0] FOL_INDEX_STEP = 4'((HEADER_BYTES + INDEX_BODY_BYTES) % 16);
    localparam logic [3:0] FOL_READ_STEP  = 4'((HEADER_BYTES + READ_BODY_BYTES) % 16);

    localparam logic [15:0] INTERVAL_RESET = 16'd32756;

    // cell length class boundaries
    localparam logic [23:0] LEN_ONE_MIN   = 24'h00000E;
    localparam logic [23:0] LEN_ONE_LIMIT = 24'h000100;
    localparam logic [23:0] LEN_TWO_LIMIT = 24'h000800;

    // cell classes
    localparam logic [1:0] CLS_ONE  = 2'd0;
    localparam logic [1:0] CLS_TWO  = 2'd1;
    localparam logic [1:0] CLS_LONG = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // stream byte codes
    localparam logic [7:0] BYTE_PAD_8 = 8'h08;
    localparam logic [7:0] BYTE_PAD_9 = 8'h09;
    localparam logic [7:0] BYTE_PAD_A = 8'h0A;
    localparam logic [7:0] BYTE_OVL   = 8'h0B;
    localparam logic [7:0] BYTE_ESC   = 8'h0C;
    localparam logic [7:0] BYTE_EOS   = 8'h0D;
    localparam logic [7:0] EOS_RUN_LEN = 8'd7;

    typedef struct packed {
        logic [23:0] len;
        logic [1:0]  cls;
        logic        index_seen;
        logic        read_due;
        logic        eos;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

`default_nettype wire

// ===== hdl/fce_front.sv =====
// Front end: accepts cell words, classifies the length and runs the read-record countdown.
// Depends on fce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fce_front
    import fce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // cell_length
    input  wire logic        s_tuser,   // index_seen
    input  wire logic        s_tlast,   // end_of_stream
    input  wire logic        q_full,
    output cmd_slot_t        push
);

    logic [15:0] interval_reg;
    logic [15:0] countdown_reg;
    logic [15:0] countdown_next;
    logic [15:0] count_dec;
    logic        accept;
    logic [1:0]  cls;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign count_dec = countdown_reg - 16'd1;

    always_comb
    begin
        if (s_tdata >= LEN_ONE_MIN && s_tdata < LEN_ONE_LIMIT)
            cls = CLS_ONE;
        else if (s_tdata < LEN_TWO_LIMIT)
            cls = CLS_TWO;
        else
            cls = CLS_LONG;
    end

    always_comb
    begin
        countdown_next = countdown_reg;
        if (accept)
        begin
            // end of stream or a countdown reaching zero restarts the countdown from the register
            if (s_tlast || count_dec == 16'd0)
                countdown_next = interval_reg;
            else
                countdown_next = count_dec;
        end
    end

    always_comb
    begin
        push.valid          = accept;
        push.cmd.len        = s_tdata;
        push.cmd.cls        = cls;
        push.cmd.index_seen = s_tuser;
        push.cmd.read_due   = (count_dec == 16'd0);
        push.cmd.eos        = s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RESET;
            countdown_reg <= INTERVAL_RESET;
        end
        else
        begin
            if (cfg_we)
                interval_reg <= cfg_wdata;
            countdown_reg <= countdown_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fce_queue.sv =====
// Two-entry command queue between the front end and the byte sequencer.
// Depends on fce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fce_queue
    import fce_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_slot_t push,
    output logic           full,
    input  wire logic      pop,
    output cmd_slot_t      head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fce_back.sv =====
// Back end: sequences stream bytes, padding and records for each queued command.
// Holds stream position, file offset and clock sums; depends on fce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fce_back
    import fce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_slot_t   head,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_OVL  = 4'd1;
    localparam logic [3:0] ST_ESC  = 4'd2;
    localparam logic [3:0] ST_HI   = 4'd3;
    localparam logic [3:0] ST_LO   = 4'd4;
    localparam logic [3:0] ST_IPAD = 4'd5;
    localparam logic [3:0] ST_IREC = 4'd6;
    localparam logic [3:0] ST_RPAD = 4'd7;
    localparam logic [3:0] ST_RREC = 4'd8;
    localparam logic [3:0] ST_END  = 4'd9;
    localparam logic [3:0] ST_EOS  = 4'd10;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_09    = 2'd1;
    localparam logic [1:0] PH_08    = 2'd2;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    cmd_t        cur_reg, cur_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  fol_reg, fol_next;
    logic [31:0] cell_sum_reg, cell_sum_next;
    logic [31:0] clk_total_reg, clk_total_next;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_rep_reg;
    logic [31:0] out_pos_reg;
    logic [31:0] out_clk_reg;
    logic        out_last_reg;

    logic        emit;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte;
    logic [7:0]  o_rep;
    logic [31:0] o_pos;
    logic [31:0] o_clk;
    logic        o_last;
    logic        out_free;

    logic [3:0]  after_bytes, after_index, after_read;
    logic [7:0]  pad_byte;
    logic [1:0]  pad_phase;
    logic [31:0] clk_sum;

    assign out_free = !out_valid_reg || m_tready;
    assign clk_sum  = clk_total_reg + {3'd0, cell_sum_reg[31:4], 1'b0};

    always_comb
    begin
        after_read  = cur_reg.eos ? ST_END : ST_IDLE;
        after_index = cur_reg.read_due ? ST_RPAD : after_read;
        after_bytes = cur_reg.index_seen ? ST_IPAD : after_index;
    end

    // padding walks 0A 09 08 groups, shortened near the 16-byte boundary
    always_comb
    begin
        unique case (phase_reg)
            PH_START:
            begin
                if (fol_reg == 4'hF)
                begin
                    pad_byte  = BYTE_PAD_8;
                    pad_phase = PH_START;
                end
                else if (fol_reg == 4'hE)
                begin
                    pad_byte  = BYTE_PAD_9;
                    pad_phase = PH_08;
                end
                else
                begin
                    pad_byte  = BYTE_PAD_A;
                    pad_phase = PH_09;
                end
            end
            PH_09:
            begin
                pad_byte  = BYTE_PAD_9;
                pad_phase = PH_08;
            end
            default:
            begin
                pad_byte  = BYTE_PAD_8;
                pad_phase = PH_START;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        fol_next       = fol_reg;
        cell_sum_next  = cell_sum_reg;
        clk_total_next = clk_total_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        o_kind         = KIND_RUN;
        o_byte         = 8'd0;
        o_rep          = 8'd1;
        o_pos          = 32'd0;
        o_clk          = 32'd0;
        o_last         = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop           = 1'b1;
                    cur_next      = head.cmd;
                    cell_sum_next = cell_sum_reg + {8'd0, head.cmd.len};
                    if (head.cmd.cls == CLS_ONE)
                        state_next = ST_LO;
                    else if (head.cmd.cls == CLS_TWO)
                        state_next = ST_HI;
                    else if (head.cmd.len[23:16] != 8'd0)
                        state_next = ST_OVL;
                    else
                        state_next = ST_ESC;
                end
            end
            ST_OVL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_byte     = BYTE_OVL;
                    o_rep      = cur_reg.len[23:16];
                    pos_next   = pos_reg + {24'd0, cur_reg.len[23:16]};
                    fol_next   = fol_reg + cur_reg.len[19:16];
                    state_next = ST_ESC;
                end
            end
            ST_ESC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_byte     = BYTE_ESC;
                    pos_next   = pos_reg + 32'd1;
                    fol_next   = fol_reg + 4'd1;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_byte     = cur_reg.len[15:8];
                    pos_next   = pos_reg + 32'd1;
                    fol_next   = fol_reg + 4'd1;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_byte     = cur_reg.len[7:0];
                    o_last     = !cur_reg.index_seen && !cur_reg.read_due && !cur_reg.eos;
                    pos_next   = pos_reg + 32'd1;
                    fol_next   = fol_reg + 4'd1;
                    state_next = after_bytes;
                end
            end
            ST_IPAD, ST_RPAD:
            begin
                if (phase_reg == PH_START && fol_reg == 4'd0)
                    state_next = (state_reg == ST_IPAD) ? ST_IREC : ST_RREC;
                else if (out_free)
                begin
                    emit       = 1'b1;
                    o_byte     = pad_byte;
                    phase_next = pad_phase;
                    pos_next   = pos_reg + 32'd1;
                    fol_next   = fol_reg + 4'd1;
                end
            end
            ST_IREC:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    o_kind         = KIND_INDEX;
                    o_pos          = pos_reg;
                    o_clk          = clk_sum;
                    o_last         = !cur_reg.read_due && !cur_reg.eos;
                    clk_total_next = clk_sum;
                    cell_sum_next  = 32'd0;
                    fol_next       = fol_reg + FOL_INDEX_STEP;
                    state_next     = after_index;
                end
            end
            ST_RREC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_kind     = KIND_READ;
                    o_pos      = pos_reg;
                    o_last     = !cur_reg.eos;
                    fol_next   = fol_reg + FOL_READ_STEP;
                    state_next = after_read;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_kind     = KIND_END;
                    o_pos      = pos_reg;
                    state_next = ST_EOS;
                end
            end
            ST_EOS:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    o_byte         = BYTE_EOS;
                    o_rep          = EOS_RUN_LEN;
                    o_last         = 1'b1;
                    // new stream starts from scratch
                    pos_next       = 32'd0;
                    fol_next       = FOL_RESET;
                    cell_sum_next  = 32'd0;
                    clk_total_next = 32'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_START;
            pos_reg       <= 32'd0;
            fol_reg       <= FOL_RESET;
            cell_sum_reg  <= 32'd0;
            clk_total_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            fol_reg       <= fol_next;
            cell_sum_reg  <= cell_sum_next;
            clk_total_reg <= clk_total_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_kind_reg <= o_kind;
            out_byte_reg <= o_byte;
            out_rep_reg  <= o_rep;
            out_pos_reg  <= o_pos;
            out_clk_reg  <= o_clk;
            out_last_reg <= o_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_clk_reg, out_pos_reg, out_rep_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/flux_cell_stream_encoder.sv =====
// Path: a cell word is written into the queue, fetched into the sequencer, and each output word
// is registered before it is shown. The sequencer fetches each cell from the queue in its idle
// state, then emits the cell's words in order, holding while the receiver stalls, with a padding
// check state ahead of each index or stream-read record. A two-entry queue lets input run ahead.
// Reset: rst_n is asynchronous, active low; it clears position, sums and queue count, sets offset 12, loads 32756.
`timescale 1ns / 1ps
`default_nettype none

module flux_cell_stream_encoder
    import fce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,   // read_record_interval
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // cell_length
    input  wire logic        s_tuser,     // index_seen
    input  wire logic        s_tlast,     // end_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,     // byte_value, repeat_count, stream_position, sample_clock
    output logic [1:0]       m_tuser,     // kind
    output logic             m_tlast      // last_of_item
);

    cmd_slot_t push;
    cmd_slot_t head;
    logic      q_full;
    logic      pop;

    fce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push)
    );

    fce_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .full (q_full),
        .pop  (pop),
        .head (head)
    );

    fce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/fce_checker.sv =====
// Port-level checker for the flux cell stream encoder, bound to the top level.
// Depends on fce_pkg and flux_cell_stream_encoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "flux_cell_stream_encoder_macros.svh"

module fce_checker
    import fce_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // stalled word holds
    `FCE_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // byte runs carry no position or clock
    `FCE_ASSERT_IMP(a_run_fields, clk, rst_n, m_tvalid && m_tuser == KIND_RUN, m_tdata[79:16] == 64'd0)

    // records carry byte zero and a count of one
    `FCE_ASSERT_IMP(a_rec_fields, clk, rst_n, m_tvalid && m_tuser != KIND_RUN, m_tdata[15:0] == 16'h0100)

    // end record is followed at once by the closing run
    `FCE_ASSERT_NXT(a_end_run, clk, rst_n, m_tvalid && m_tready && m_tuser == KIND_END, m_tvalid && m_tuser == KIND_RUN && m_tdata[7:0] == BYTE_EOS && m_tlast)

endmodule

bind flux_cell_stream_encoder fce_checker u_fce_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

`default_nettype wire

// ===== tb/tb_flux_cell_stream_encoder.sv =====
// Self-checking bench for flux_cell_stream_encoder: cell words in, stream/record words out.
// Keeps its own encoder state to predict output words; needs fce_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_flux_cell_stream_encoder;
    import fce_pkg::*;

    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  byte_val;
        logic [7:0]  repeat_cnt;
        logic [31:0] position;
        logic [31:0] sample_clk;
        logic        last;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // encoder state as the block should hold it
    logic [15:0] interval_reg;
    logic [31:0] stream_bytes;
    logic [3:0]  offset_mod16;
    logic [31:0] sum_since_index;
    logic [31:0] clock_acc;
    logic [15:0] read_left;
    logic [31:0] cell_bytes;

    word_t expected_words[$];
    int    n_errors = 0;

    // stimulus controls, written by the test sequence only
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int hold_token = 0;

    flux_cell_stream_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void restart_stream();
        stream_bytes    = '0;
        offset_mod16    = FOL_RESET;
        sum_since_index = '0;
        clock_acc       = '0;
        read_left       = interval_reg;
    endfunction

    function automatic void push_word(logic [1:0] kind, logic [7:0] b, logic [7:0] rep,
                                      logic [31:0] pos, logic [31:0] sclk);
        word_t w;
        w.kind       = kind;
        w.byte_val   = b;
        w.repeat_cnt = rep;
        w.position   = pos;
        w.sample_clk = sclk;
        w.last       = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        offset_mod16 = offset_mod16 + 4'd1;
        cell_bytes   = cell_bytes + 32'd1;
        push_word(KIND_RUN, b, 8'd1, '0, '0);
    endfunction

    function automatic void pad_to_16();
        logic [4:0] rem;
        while (offset_mod16 != 4'd0)
        begin
            rem = 5'd16 - 5'(offset_mod16);
            if (rem >= 5'd3)
                push_byte(BYTE_PAD_A);
            if (rem >= 5'd2)
                push_byte(BYTE_PAD_9);
            push_byte(BYTE_PAD_8);
        end
    endfunction

    function automatic void encode_cell(logic [23:0] len, logic idx, logic eos);
        logic [31:0] v;
        logic [7:0]  ovl;
        v = {8'd0, len};
        cell_bytes = '0;
        sum_since_index = sum_since_index + v;

        if (len >= LEN_ONE_MIN && len < LEN_ONE_LIMIT)
            push_byte(v[7:0]);
        else if (len < LEN_TWO_LIMIT)
        begin
            push_byte(v[15:8]);
            push_byte(v[7:0]);
        end
        else
        begin
            ovl = v[23:16];
            if (ovl != 8'd0)
            begin
                // overflow bytes come out as one run word
                push_word(KIND_RUN, BYTE_OVL, ovl, '0, '0);
                offset_mod16 = offset_mod16 + ovl[3:0];
                cell_bytes   = cell_bytes + 32'(ovl);
            end
            push_byte(BYTE_ESC);
            push_byte(v[15:8]);
            push_byte(v[7:0]);
        end

        if (idx)
        begin
            pad_to_16();
            clock_acc = clock_acc + (sum_since_index / 32'd16) * 32'd2;
            sum_since_index = '0;
            push_word(KIND_INDEX, 8'd0, 8'd1, stream_bytes + cell_bytes, clock_acc);
            offset_mod16 = offset_mod16 + FOL_INDEX_STEP;
        end

        read_left = read_left - 16'd1;
        if (read_left == 16'd0)
        begin
            pad_to_16();
            push_word(KIND_READ, 8'd0, 8'd1, stream_bytes + cell_bytes, '0);
            offset_mod16 = offset_mod16 + FOL_READ_STEP;
            read_left = interval_reg;
        end

        stream_bytes = stream_bytes + cell_bytes;

        if (eos)
        begin
            push_word(KIND_END, 8'd0, 8'd1, stream_bytes, '0);
            push_word(KIND_RUN, BYTE_EOS, EOS_RUN_LEN, '0, '0);
            restart_stream();
        end

        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual kind %0d tdata %h",
                         $time, m_tuser, m_tdata);
                n_errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("kind", 32'(want.kind), 32'(m_tuser));
                compare_field("byte_value", 32'(want.byte_val), 32'(m_tdata[7:0]));
                compare_field("repeat_count", 32'(want.repeat_cnt), 32'(m_tdata[15:8]));
                compare_field("stream_position", want.position, m_tdata[47:16]);
                compare_field("sample_clock", want.sample_clk, m_tdata[79:48]);
                compare_field("last_of_item", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // receiver: random stall after each word unless rx_steady is set, plus a long hold-off on request
    int rx_left = 0;
    int hold_seen = 0;

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            rx_left = LONG_HOLD;
        end
        if (rx_left > 0)
        begin
            rx_left--;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready && !rx_steady)
        begin
            rx_left = $urandom_range(0, 13);
            if (rx_left > 0)
            begin
                rx_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------------------------------------------------------- stimulus

    // tvalid is left high after the handshake so back-to-back words need no toggle
    task automatic send_cell(logic [23:0] len, logic idx, logic eos);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        s_tuser  <= idx;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_cell(len, idx, eos);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_interval(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        interval_reg = value;
    endtask

    function automatic logic [23:0] pick_length();
        logic [23:0] bounds [10] = '{24'h0, 24'hD, 24'hE, 24'hFF, 24'h100,
                                     24'h7FF, 24'h800, 24'hFFFF, 24'h10000, 24'hFFFFFF};
        case ($urandom_range(0, 9))
            0:       return 24'($urandom_range(0, 13));
            1, 2, 3: return 24'($urandom_range(14, 255));
            4, 5:    return 24'($urandom_range(256, 2047));
            6:       return 24'($urandom_range(2048, 65535));
            7:       return 24'($urandom_range(65536, 24'hFFFFFF));
            8:       return bounds[$urandom_range(0, 9)];
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_cell_lengths();
        logic [23:0] lens [12] = '{24'h0, 24'hD, 24'hE, 24'hFF, 24'h100, 24'h7FF,
                                   24'h800, 24'hFFFF, 24'h10000, 24'hFFFFFF,
                                   24'h555555, 24'hAAAAAA};
        foreach (lens[i])
            send_cell(lens[i], 1'b0, 1'b0);
        send_cell(24'h42, 1'b1, 1'b0);
        send_cell(24'h123, 1'b0, 1'b1);
        settle();
    endtask

    // new interval only takes hold at the next reload, hence the end-of-stream cells
    task automatic test_record_order();
        write_interval(16'd1);
        send_cell(24'h20, 1'b0, 1'b1);
        send_cell(24'h30, 1'b0, 1'b0);
        send_cell(24'h1234, 1'b1, 1'b0);
        send_cell(24'h05, 1'b1, 1'b1);
        settle();
        // zero interval: countdown wraps, first record only at the 65536th cell
        write_interval(16'd0);
        send_cell(24'h40, 1'b0, 1'b1);
        send_cell(24'h0101, 1'b0, 1'b0);
        send_cell(24'h0C0C, 1'b0, 1'b0);
        settle();
        write_interval(16'hFFFF);
        send_cell(24'h50, 1'b0, 1'b1);
        settle();
    endtask

    // back-to-back maximum-length cells: long overflow runs and a large clock step at the index
    task automatic test_long_cells();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (20)
            send_cell(24'hFFFFFF, 1'b0, 1'b0);
        send_cell(24'h10, 1'b1, 1'b0);
        send_cell(24'h11, 1'b0, 1'b1);
        settle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        write_interval(16'd5);
        send_cell(24'h22, 1'b0, 1'b1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        hold_token++;
        repeat (30)
            send_cell(pick_length(), ($urandom_range(0, 5) == 0), 1'b0);
        settle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random();
        logic [15:0] intervals [4];
        intervals = '{16'd2, 16'($urandom_range(3, 12)), 16'd1, 16'($urandom_range(13, 40))};
        for (int p = 0; p < 4; p++)
        begin
            write_interval(intervals[p]);
            tx_steady = (p == 2);
            rx_steady = (p == 3);
            send_cell(pick_length(), 1'b0, 1'b1);
            repeat (23)
                send_cell(pick_length(), ($urandom_range(0, 7) == 0),
                          ($urandom_range(0, 24) == 0));
            settle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        interval_reg = INTERVAL_RESET;
        restart_stream();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cell_lengths();
        test_record_order();
        test_long_cells();
        test_backpressure();
        test_random();

        settle();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== flux_cell_stream_encoder.f =====
+incdir+hdl
hdl/fce_pkg.sv
hdl/fce_front.sv
hdl/fce_queue.sv
hdl/fce_back.sv
hdl/flux_cell_stream_encoder.sv
hdl/fce_checker.sv
tb/tb_flux_cell_stream_encoder.sv
